// ===== sv/ipa_pkg.sv =====
// Shared types and constants for the identifier pool allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ipa_pkg;

  localparam int ID_W         = 11;
  localparam int OP_W         = 2;
  localparam int ST_W         = 2;
  localparam int WORD_W       = 32;
  localparam int WORD_LSB     = 5;
  localparam int CAPACITY_DEF = 1024;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
  localparam logic [OP_W-1:0] OP_GROW  = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_SAME = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] new_size;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic [ID_W-1:0] used_count;
    logic [ST_W-1:0] status;
  } out_item_t;

endpackage

// ===== sv/ipa_mod_unit.sv =====
// Iterative remainder unit: one restoring step per cycle over ID_W bits.
// Depends on ipa_pkg.
`timescale 1ns / 1ps

module ipa_mod_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [ipa_pkg::ID_W-1:0] dividend,
  input  logic [ipa_pkg::ID_W-1:0] divisor,
  output logic                   done,
  output logic [ipa_pkg::ID_W-1:0] remainder
);
  import ipa_pkg::*;

  localparam int CntW = $clog2(ID_W + 1);

  logic            active_r;
  logic [CntW-1:0] cnt_r;
  logic [ID_W-1:0] rem_r;
  logic [ID_W-1:0] dq_r;
  logic [ID_W:0]   shifted;
  logic [ID_W:0]   trial;

  assign shifted = {rem_r, dq_r[ID_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (start) begin
      active_r <= 1'b1;
      cnt_r    <= CntW'(ID_W);
    end else if (active_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        active_r <= 1'b0;
      end
    end
  end

  // a borrow out of the trial subtract means the divisor did not fit: restore
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
    end else if (active_r && cnt_r != '0) begin
      dq_r  <= {dq_r[ID_W-2:0], 1'b0};
      rem_r <= trial[ID_W] ? shifted[ID_W-1:0] : trial[ID_W-1:0];
    end
  end

  assign done      = active_r && (cnt_r == '0);
  assign remainder = rem_r;

endmodule

// ===== sv/ipa_map_store.sv =====
// Used-slot bitmap held as words of WORD_W bits, one read and one write port.
// A word never written since reset reads as all free. Depends on ipa_pkg.
`timescale 1ns / 1ps

module ipa_map_store #(
  parameter int WORDS = ipa_pkg::CAPACITY_DEF / ipa_pkg::WORD_W,
  parameter int AW    = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [ipa_pkg::WORD_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [ipa_pkg::WORD_W-1:0] wr_data
);
  import ipa_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  valid_r;
  logic [WORD_W-1:0] rd_word_r;
  logic              rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule

// ===== sv/ipa_scan_unit.sv =====
// Free-slot finder for one bitmap word: masks the slots outside the pool and
// before the scan start, then picks the lowest free bit. Depends on ipa_pkg.
`timescale 1ns / 1ps

module ipa_scan_unit (
  input  logic [ipa_pkg::WORD_W-1:0]   word,
  input  logic                         at_last,
  input  logic [ipa_pkg::WORD_LSB-1:0] lim_bit,
  input  logic                         first,
  input  logic [ipa_pkg::WORD_LSB-1:0] start_bit,
  output logic                         found,
  output logic [ipa_pkg::WORD_LSB-1:0] bit_idx
);
  import ipa_pkg::*;

  localparam logic [WORD_W-1:0] ONES = '1;

  logic [WORD_W-1:0] free_vec;

  always_comb begin
    free_vec = ~word;
    // drop slots beyond the end of the pool in its last word
    if (at_last) begin
      free_vec = free_vec & (ONES >> (WORD_LSB'(WORD_W - 1) - lim_bit));
    end
    if (first) begin
      free_vec = free_vec & (ONES << start_bit);
    end
  end

  always_comb begin
    bit_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        bit_idx = WORD_LSB'(b);
      end
    end
  end

  assign found = |free_vec;

endmodule

// ===== sv/id_pool_next_fit_allocator_unit.sv =====
// Identifier pool with next-fit allocation: top level and sequencer.
// Depends on ipa_pkg, ipa_mod_unit, ipa_map_store and ipa_scan_unit.
//
// Usage: drive in_item and raise start; the item transfers at a rising edge
// with start high and busy low. Each item gives one result on out_item,
// marked by out_valid for exactly one cycle; the receiver must take it then.
// Path from the accepting edge to out_valid:
//   grow, allocate on a full pool, free/mark on an empty pool: in the cycle after.
//   free / mark: the bit-serial remainder unit, then a bitmap read and update.
//   allocate: a read of the start word, then one word more per bitmap word
//   visited after the first, the scan unit reading one WORD_W-bit word of
//   the bitmap RAM per cycle.
// busy is high while an item is in the sequencer; the next item may follow
// on the cycle after out_valid, or straight away after an item answered from idle.
// Reset empties the pool (size 0) and takes effect at once: per-word valid
// flags make every bitmap word read as free until it is first written, so no
// clearing pass is needed. Growing the pool leaves the bitmap untouched.
`timescale 1ns / 1ps

module id_pool_next_fit_allocator_unit #(
  parameter int CAPACITY = ipa_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ipa_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output ipa_pkg::out_item_t out_item
);
  import ipa_pkg::*;

  localparam int WORDS  = (CAPACITY + WORD_W - 1) / WORD_W;
  localparam int WA     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MAX_ID = (1 << ID_W) - 1;
  localparam logic [ID_W-1:0] CAP_SAT = ID_W'((CAPACITY > MAX_ID) ? MAX_ID : CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EVAL = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [ID_W-1:0]     pool_r, pool_nxt;
  logic [ID_W-1:0]     free_r, free_nxt;
  logic [ID_W-1:0]     cursor_r, cursor_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [WA-1:0]       word_r, word_nxt;
  logic [WORD_LSB-1:0] bit_r, bit_nxt;
  logic                first_r, first_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                rd_en, wr_en;
  logic [WA-1:0]       rd_addr;
  logic [WORD_W-1:0]   rd_data, wr_data, bit_mask;
  logic                mod_start, mod_done;
  logic [ID_W-1:0]     mod_rem, mod_slot;
  logic                scan_found;
  logic [WORD_LSB-1:0] scan_bit;
  logic [ID_W-1:0]     scan_slot;
  logic [ID_W-1:0]     last_slot, start_slot, req_sat, res_id;
  logic [WA-1:0]       last_word, next_word;
  logic [ST_W-1:0]     res_st;
  logic                finish;

  assign last_slot  = pool_r - 1'b1;
  assign last_word  = WA'(last_slot >> WORD_LSB);
  assign start_slot = (cursor_r == pool_r) ? '0 : cursor_r;
  assign next_word  = (word_r == last_word) ? '0 : word_r + 1'b1;
  assign req_sat    = (in_item.new_size > CAP_SAT) ? CAP_SAT : in_item.new_size;
  // identifier zero wraps to the last slot
  assign mod_slot   = (mod_rem == '0) ? last_slot : mod_rem - 1'b1;
  assign scan_slot  = ID_W'({word_r, scan_bit});
  assign bit_mask   = WORD_W'(1) << ((op_r == OP_ALLOC) ? scan_bit : bit_r);

  ipa_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_item.id),
    .divisor   (pool_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  ipa_map_store #(
    .WORDS (WORDS),
    .AW    (WA)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (word_r),
    .wr_data (wr_data)
  );

  ipa_scan_unit u_scan (
    .word      (rd_data),
    .at_last   (word_r == last_word),
    .lim_bit   (last_slot[WORD_LSB-1:0]),
    .first     (first_r),
    .start_bit (bit_r),
    .found     (scan_found),
    .bit_idx   (scan_bit)
  );

  always_comb begin
    state_nxt     = state_r;
    pool_nxt      = pool_r;
    free_nxt      = free_r;
    cursor_nxt    = cursor_r;
    op_nxt        = op_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    first_nxt     = first_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rd_en         = 1'b0;
    rd_addr       = word_r;
    wr_en         = 1'b0;
    wr_data       = rd_data ^ bit_mask;
    mod_start     = 1'b0;
    res_id        = '0;
    res_st        = ST_DONE;
    finish        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_item.opcode;
          case (in_item.opcode)
            OP_ALLOC: begin
              if (free_r != '0 && pool_r != '0) begin
                word_nxt  = WA'(start_slot >> WORD_LSB);
                bit_nxt   = start_slot[WORD_LSB-1:0];
                first_nxt = 1'b1;
                state_nxt = S_READ;
              end else begin
                res_st = ST_FULL;
                finish = 1'b1;
              end
            end
            OP_FREE, OP_MARK: begin
              if (pool_r == '0) begin
                res_st = ST_ZERO;
                finish = 1'b1;
              end else begin
                mod_start = 1'b1;
                state_nxt = S_MOD;
              end
            end
            default: begin
              if (req_sat <= pool_r) begin
                res_st = ST_SAME;
              end else begin
                free_nxt = free_r + (req_sat - pool_r);
                pool_nxt = req_sat;
              end
              finish = 1'b1;
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          word_nxt  = WA'(mod_slot >> WORD_LSB);
          bit_nxt   = mod_slot[WORD_LSB-1:0];
          first_nxt = 1'b0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (op_r == OP_ALLOC) begin
          if (scan_found) begin
            wr_en      = 1'b1;
            free_nxt   = free_r - 1'b1;
            cursor_nxt = scan_slot + 1'b1;
            res_id     = scan_slot + 1'b1;
            finish     = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            // fetch the following word, wrapping at the end of the pool
            rd_en     = 1'b1;
            rd_addr   = next_word;
            word_nxt  = next_word;
            first_nxt = 1'b0;
          end
        end else begin
          if (rd_data[bit_r] == (op_r == OP_FREE)) begin
            wr_en    = 1'b1;
            free_nxt = (op_r == OP_FREE) ? free_r + 1'b1 : free_r - 1'b1;
          end else begin
            res_st = ST_SAME;
          end
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.result_id  = res_id;
      out_item_nxt.used_count = pool_nxt - free_nxt;
      out_item_nxt.status     = res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pool_r      <= '0;
      free_r      <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_r      <= pool_nxt;
      free_r      <= free_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    first_r    <= first_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe raised while an item is still in flight");

  a_cursor_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= pool_r)
    else $error("next-fit cursor beyond pool size");

  a_free_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= pool_r)
    else $error("free count exceeds pool size");

  a_alloc_id_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.result_id != '0) |-> (out_item.status == ST_DONE))
    else $error("identifier returned with a non-done status");
`endif

endmodule

// ===== dv/id_pool_next_fit_allocator_unit_tb.sv =====
// Self-checking testbench for id_pool_next_fit_allocator_unit: a directed table, then
// random phases of allocate/free/mark/grow traffic and a top-of-pool tail, checked against a behavioural pool.
// Depends on ipa_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module id_pool_next_fit_allocator_unit_tb;
  import ipa_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int ID_MAX       = (1 << ID_W) - 1;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 3;
  localparam int PHASE_ITEMS  = 540;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } step_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // behavioural copy of the pool
  bit        slot_used [CAP];
  int        pool_sz;
  int        pool_free;
  int        pool_cur;

  out_item_t pending_q[$];
  int        errors;
  int        items_sent;
  int        results_seen;
  int        stall_cycles;
  int        status_seen [4];

  id_pool_next_fit_allocator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Apply one item to the pool copy and return the result it should give.
  function automatic out_item_t pool_apply(in_item_t it);
    out_item_t r;
    int        req;
    int        s;
    bit        found;
    r.result_id = '0;
    r.status    = ST_DONE;
    case (it.opcode)
      OP_ALLOC: begin
        r.status = ST_FULL;
        found    = 1'b0;
        if (pool_free > 0 && pool_sz > 0) begin
          for (int i = 0; i < pool_sz && !found; i++) begin
            s = (i + pool_cur) % pool_sz;
            if (!slot_used[s]) begin
              slot_used[s] = 1'b1;
              pool_cur     = s + 1;
              pool_free--;
              r.result_id  = ID_W'(s + 1);
              r.status     = ST_DONE;
              found        = 1'b1;
            end
          end
        end
      end
      OP_FREE, OP_MARK: begin
        if (pool_sz == 0) begin
          r.status = ST_ZERO;
        end else begin
          // id 0 wraps onto the last slot
          s = (int'(it.id) % pool_sz + pool_sz - 1) % pool_sz;
          if (it.opcode == OP_FREE) begin
            if (slot_used[s]) begin
              slot_used[s] = 1'b0;
              pool_free++;
            end else begin
              r.status = ST_SAME;
            end
          end else begin
            if (!slot_used[s]) begin
              slot_used[s] = 1'b1;
              pool_free--;
            end else begin
              r.status = ST_SAME;
            end
          end
        end
      end
      default: begin
        req = (int'(it.new_size) > CAP) ? CAP : int'(it.new_size);
        if (req <= pool_sz) begin
          r.status = ST_SAME;
        end else begin
          for (int i = pool_sz; i < req; i++) slot_used[i] = 1'b0;
          pool_free += req - pool_sz;
          pool_sz    = req;
        end
      end
    endcase
    r.used_count = ID_W'(pool_sz - pool_free);
    return r;
  endfunction

  function automatic step_t row(logic [OP_W-1:0] op, int id, int ns, bit typed = 1'b0,
                                int rid = 0, int used = 0, logic [ST_W-1:0] st = ST_DONE);
    step_t r;
    r.stim.opcode     = op;
    r.stim.id         = ID_W'(id);
    r.stim.new_size   = ID_W'(ns);
    r.typed           = typed;
    r.want.result_id  = ID_W'(rid);
    r.want.used_count = ID_W'(used);
    r.want.status     = st;
    return r;
  endfunction

  // Pick the id of a slot in use, sometimes written as an alias or as 0.
  function automatic int pick_used_id();
    int origin;
    int s;
    origin = $urandom_range(0, pool_sz - 1);
    for (int k = 0; k < pool_sz; k++) begin
      s = (origin + k) % pool_sz;
      if (slot_used[s]) begin
        case ($urandom_range(0, 3))
          0:       return (s == pool_sz - 1) ? 0 : s + 1;
          1:       return s + 1 + pool_sz * $urandom_range(0, (ID_MAX - s - 1) / pool_sz);
          default: return s + 1;
        endcase
      end
    end
    return $urandom_range(0, ID_MAX);
  endfunction

  function automatic in_item_t pool_traffic(int cap);
    in_item_t it;
    int       r;
    it.id       = ID_W'($urandom_range(0, ID_MAX));
    it.new_size = ID_W'($urandom_range(0, ID_MAX));
    r           = $urandom_range(0, 99);
    if (pool_sz == 0 || r < 6) begin
      it.opcode = OP_GROW;
      if ($urandom_range(0, 9) == 0)
        it.new_size = ID_W'($urandom_range(0, pool_sz));
      else
        it.new_size = ID_W'((pool_sz + 8 > cap) ? cap : pool_sz + $urandom_range(1, 8));
    end else if (r < 50) begin
      it.opcode = OP_ALLOC;
    end else if (r < 78) begin
      it.opcode = OP_FREE;
      it.id     = ID_W'(pick_used_id());
    end else if (r < 88) begin
      it.opcode = OP_MARK;
      it.id     = ID_W'($urandom_range(1, pool_sz));
    end else begin
      // noise: any id at all
      it.opcode = ($urandom_range(0, 1) != 0) ? OP_FREE : OP_MARK;
    end
    return it;
  endfunction

  function automatic int idle_gap(int pct);
    int g = 0;
    while (g < 40 && $urandom_range(0, 99) < pct) g++;
    return g;
  endfunction

  // Hold the item until it transfers, then record what it should produce.
  task automatic send_step(step_t st, int gap);
    out_item_t pred;
    in_item <= st.stim;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    pred = pool_apply(st.stim);
    pending_q.push_back(st.typed ? st.want : pred);
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      status_seen[out_item.status]++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with none expected: id %0d used %0d status %0d", $time,
                 out_item.result_id, out_item.used_count, out_item.status);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_item.result_id !== want.result_id) begin
          $display("%0t: result_id expected %0d actual %0d", $time, want.result_id,
                   out_item.result_id);
          errors++;
        end
        if (out_item.used_count !== want.used_count) begin
          $display("%0t: used_count expected %0d actual %0d", $time, want.used_count,
                   out_item.used_count);
          errors++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_item.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    step_t directed[$];
    step_t tail[$];
    step_t st;
    int    idle_pct [PHASES];
    int    size_cap [PHASES];

    idle_pct = '{0, 59, 20};
    size_cap = '{24, 200, 600};

    // empty pool, then a pool of four filled, wrapped and aliased
    directed.push_back(row(OP_ALLOC, 0, 0, 1'b1, 0, 0, ST_FULL));
    directed.push_back(row(OP_FREE, 5, 0, 1'b1, 0, 0, ST_ZERO));
    directed.push_back(row(OP_MARK, 0, 0, 1'b1, 0, 0, ST_ZERO));
    directed.push_back(row(OP_GROW, 0, 0, 1'b1, 0, 0, ST_SAME));
    directed.push_back(row(OP_GROW, 0, 4, 1'b1, 0, 0, ST_DONE));
    directed.push_back(row(OP_ALLOC, 0, 0));
    directed.push_back(row(OP_ALLOC, ID_MAX, ID_MAX));
    directed.push_back(row(OP_MARK, 0, 0));
    directed.push_back(row(OP_ALLOC, 0, 0));
    directed.push_back(row(OP_ALLOC, 0, 0, 1'b1, 0, 4, ST_FULL));
    directed.push_back(row(OP_FREE, 0, 0));
    directed.push_back(row(OP_FREE, 4, 0, 1'b1, 0, 3, ST_SAME));
    directed.push_back(row(OP_MARK, 6, 0, 1'b1, 0, 3, ST_SAME));
    directed.push_back(row(OP_ALLOC, 0, 0));
    directed.push_back(row(OP_FREE, ID_MAX, 0));
    directed.push_back(row(OP_FREE, CAP, 0));
    directed.push_back(row(OP_ALLOC, 0, 0));
    directed.push_back(row(OP_GROW, 0, 2, 1'b1, 0, 3, ST_SAME));
    directed.push_back(row(OP_GROW, 0, 6));
    directed.push_back(row(OP_ALLOC, 0, 0));
    directed.push_back(row(OP_ALLOC, 0, 0));
    directed.push_back(row(OP_ALLOC, 0, 0));
    directed.push_back(row(OP_ALLOC, 0, 0, 1'b1, 0, 6, ST_FULL));
    directed.push_back(row(OP_FREE, 1, 0));
    directed.push_back(row(OP_ALLOC, 0, 0));

    // grow past capacity, then work the top slots
    tail.push_back(row(OP_GROW, 0, ID_MAX));
    tail.push_back(row(OP_GROW, 0, 1500));
    tail.push_back(row(OP_GROW, 0, CAP));
    tail.push_back(row(OP_MARK, CAP, 0));
    tail.push_back(row(OP_FREE, 0, 0));
    tail.push_back(row(OP_ALLOC, 0, 0));
    tail.push_back(row(OP_FREE, ID_MAX, 0));
    tail.push_back(row(OP_ALLOC, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_step(directed[i], 0);

    st.typed = 1'b0;
    st.want  = '0;
    for (int p = 0; p < PHASES; p++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        st.stim = pool_traffic(size_cap[p]);
        send_step(st, idle_gap(idle_pct[p]));
      end
    end

    foreach (tail[i]) send_step(tail[i], idle_gap(20));
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (directed, %0d random phases, top-of-pool tail), %0d results in;",
             items_sent, PHASES, results_seen);
    $display("pool reached %0d ids; status done %0d, full %0d, no change %0d, zero size %0d",
             pool_sz, status_seen[ST_DONE], status_seen[ST_FULL], status_seen[ST_SAME],
             status_seen[ST_ZERO]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ipa_pkg.sv
sv/ipa_mod_unit.sv
sv/ipa_map_store.sv
sv/ipa_scan_unit.sv
sv/id_pool_next_fit_allocator_unit.sv
dv/id_pool_next_fit_allocator_unit_tb.sv
